>>> rtl/core/lbs_pkg.sv
// Shared types and constants for the local background subtract unit.
package lbs_pkg;

    localparam int PIX_W   = 16;
    localparam int COORD_W = 9;
    localparam int CFG_W   = 16;
    localparam int DIM_W   = 10;
    localparam int RAD_W   = 6;
    localparam int WIN_W   = RAD_W + 1;
    localparam int AREA_W  = 2 * WIN_W;
    localparam int QUO_W   = PIX_W;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 2;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 10'd512;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 10'd512;
    localparam logic [RAD_W-1:0] RST_RADIUS       = 6'd15;
    localparam logic [PIX_W-1:0] RST_BASELINE     = 16'd8192;
    localparam logic [PIX_W-1:0] PIX_MAX          = 16'hFFFF;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUTSIDE   = 2'd2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS       = 2'd2;
    localparam logic [IDX_W-1:0] REG_BASELINE     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_WR,
        S_Q_RD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN
    } t_state;

endpackage

>>> rtl/core/lbs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module lbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> rtl/core/lbs_div.sv
// Iterative restoring divider, one quotient bit per cycle, quotient below 2^QUO_W.
module lbs_div #(
    parameter int DIVD_W = 34
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DIVD_W-1:0]          i_dividend,
    input  logic [lbs_pkg::AREA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [lbs_pkg::QUO_W-1:0]  o_quotient
);
    import lbs_pkg::*;

    localparam int RW = (DIVD_W > AREA_W + QUO_W) ? DIVD_W : AREA_W + QUO_W;
    localparam int BW = $clog2(QUO_W);

    logic [RW-1:0]     r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [BW-1:0]     r_bit;
    logic [AREA_W-1:0] r_div;
    logic              r_busy;
    logic              r_done;
    logic [RW-1:0]     trial;
    logic              fits;

    assign trial = RW'(r_div) << r_bit;
    assign fits  = (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_bit == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == '0)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_rem <= RW'(i_dividend);
            r_div <= i_divisor;
            r_quo <= '0;
            r_bit <= BW'(QUO_W - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_rem        <= r_rem - trial;
                r_quo[r_bit] <= 1'b1;
            end
            r_bit <= r_bit - BW'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/core/local_background_subtract_unit.sv
// Top level: frame loader with summed-area table and windowed background subtraction.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_operation, i_pixel_value, i_query_col/row
//  output   | o_out_valid / i_out_ready  | o_corrected_pixel, o_status
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A load reads the table on acceptance, then read-modify-writes the prefix sum.
// A good query is accepted, makes the four table reads through the single read port,
// runs the divider (16 quotient bits) and then forms the result. An error query goes
// from acceptance straight to the result step. Reset is synchronous; border table entries
// read as zero by address, so no clearing pass is needed. A full output register stalls
// only the final step of a query; loads go on.
module local_background_subtract_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [lbs_pkg::PIX_W-1:0]   i_pixel_value,
    input  logic [lbs_pkg::COORD_W-1:0] i_query_col,
    input  logic [lbs_pkg::COORD_W-1:0] i_query_row,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lbs_pkg::PIX_W-1:0]   o_corrected_pixel,
    output logic [lbs_pkg::STAT_W-1:0]  o_status,
    input  logic                        i_cfg_we,
    input  logic [lbs_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lbs_pkg::CFG_W-1:0]   i_cfg_data
);
    import lbs_pkg::*;

    localparam int DWX   = $clog2(MAX_WIDTH + 1);
    localparam int DWY   = $clog2(MAX_HEIGHT + 1);
    localparam int DWM   = (DWX > DWY) ? DWX : DWY;
    localparam int CW    = ((DWM > COORD_W) ? DWM : COORD_W) + 1;
    localparam int EWX   = (DWX > DIM_W) ? DWX : DIM_W;
    localparam int EWY   = (DWY > DIM_W) ? DWY : DIM_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RSW   = PIX_W + $clog2(MAX_WIDTH);
    localparam int PW    = RSW + $clog2(MAX_HEIGHT);

    t_state r_state, n_state;

    logic [DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [RAD_W-1:0]  r_radius;
    logic [PIX_W-1:0]  r_base;

    logic [DWX-1:0]    r_col, n_col;
    logic [DWY-1:0]    r_row, n_row;
    logic [RSW-1:0]    r_rsum, n_rsum;
    logic              r_frame_done, n_frame_done;

    logic [CW-1:0]     r_top, n_top, r_bot, n_bot, r_left, n_left, r_right, n_right;
    logic [2:0]        r_step, n_step;
    logic [PW-1:0]     r_acc, n_acc;
    logic              r_zero, n_zero;
    logic [AREA_W-1:0] r_area, n_area;
    logic [PIX_W-1:0]  r_pix, n_pix;
    logic [STAT_W-1:0] r_status, n_status;

    logic              r_out_valid, n_out_valid;
    logic [PIX_W-1:0]  r_out_pix, n_out_pix;
    logic [STAT_W-1:0] r_out_status, n_out_status;

    logic              px_we, ps_we;
    logic [AW-1:0]     px_waddr, px_raddr, ps_waddr, ps_raddr;
    logic [PIX_W-1:0]  px_wdata, px_rdata;
    logic [PW-1:0]     ps_wdata, ps_rdata, rd_sat;

    logic              div_start, div_done;
    logic [QUO_W-1:0]  div_quo;

    logic [DWX-1:0]    w_eff;
    logic [DWY-1:0]    h_eff;
    logic [EWX-1:0]    w_ext;
    logic [EWY-1:0]    h_ext;
    logic              in_acc, out_free, cfg_restart;
    logic [CW-1:0]     qx, qy, qr, ysum, xsum;
    logic [STAT_W-1:0] q_status;

    function automatic logic [AW-1:0] sat_addr(input logic [CW-1:0] row,
                                               input logic [CW-1:0] col);
        logic [AW-1:0] a;
        a = AW'(row - CW'(1)) * AW'(MAX_WIDTH) + AW'(col - CW'(1));
        return a;
    endfunction

    // effective frame size: zero acts as one, large values saturate
    assign w_ext = EWX'(r_cfg_w);
    assign h_ext = EWY'(r_cfg_h);
    assign w_eff = (r_cfg_w == '0) ? DWX'(1) :
                   (w_ext > EWX'(MAX_WIDTH)) ? DWX'(MAX_WIDTH) : DWX'(w_ext);
    assign h_eff = (r_cfg_h == '0) ? DWY'(1) :
                   (h_ext > EWY'(MAX_HEIGHT)) ? DWY'(MAX_HEIGHT) : DWY'(h_ext);

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign cfg_restart = i_cfg_we &&
                         ((i_cfg_index == REG_FRAME_WIDTH) || (i_cfg_index == REG_FRAME_HEIGHT));
    assign rd_sat      = r_zero ? '0 : ps_rdata;

    assign qx   = CW'(i_query_col);
    assign qy   = CW'(i_query_row);
    assign qr   = CW'(r_radius);
    assign xsum = qx + qr + CW'(1);
    assign ysum = qy + qr + CW'(1);

    always_comb begin
        if (!r_frame_done) begin
            q_status = ST_NOT_READY;
        end else if ((qx >= CW'(w_eff)) || (qy >= CW'(h_eff))) begin
            q_status = ST_OUTSIDE;
        end else begin
            q_status = ST_OK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == OP_LOAD) begin
                        n_state = S_LD_WR;
                    end else if (q_status == ST_OK) begin
                        n_state = S_Q_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LD_WR:    n_state = S_IDLE;
            S_Q_RD: begin
                if (r_step == 3'd4) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic             restart;
        logic [DWX-1:0]   ld_col;
        logic [DWY-1:0]   ld_row;
        logic [DWX:0]     col_inc;
        logic [DWY:0]     row_inc;
        logic [CW-1:0]    rr, cc;
        logic [PIX_W:0]   lift, diff;

        n_col        = r_col;
        n_row        = r_row;
        n_rsum       = r_rsum;
        n_frame_done = r_frame_done;
        n_top        = r_top;
        n_bot        = r_bot;
        n_left       = r_left;
        n_right      = r_right;
        n_step       = r_step;
        n_acc        = r_acc;
        n_zero       = r_zero;
        n_area       = r_area;
        n_pix        = r_pix;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_pix    = r_out_pix;
        n_out_status = r_out_status;
        px_we        = 1'b0;
        px_waddr     = '0;
        px_wdata     = i_pixel_value;
        px_raddr     = '0;
        ps_we        = 1'b0;
        ps_waddr     = AW'(r_row) * AW'(MAX_WIDTH) + AW'(r_col);
        ps_wdata     = rd_sat + PW'(r_rsum);
        ps_raddr     = '0;
        div_start    = 1'b0;

        restart = r_frame_done || (r_col >= w_eff) || (r_row >= h_eff);
        ld_col  = restart ? '0 : r_col;
        ld_row  = restart ? '0 : r_row;
        col_inc = {1'b0, r_col} + (DWX + 1)'(1);
        row_inc = {1'b0, r_row} + (DWY + 1)'(1);
        rr      = r_bot;
        cc      = r_right;
        lift    = {1'b0, r_base} + {1'b0, r_pix};
        diff    = lift - {1'b0, div_quo};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_operation == OP_LOAD)) begin
                    n_col        = ld_col;
                    n_row        = ld_row;
                    n_rsum       = (restart ? '0 : r_rsum) + RSW'(i_pixel_value);
                    n_frame_done = 1'b0;
                    px_we        = 1'b1;
                    px_waddr     = AW'(ld_row) * AW'(MAX_WIDTH) + AW'(ld_col);
                    // entry above: same column in the previous row
                    ps_raddr     = sat_addr(CW'(ld_row), CW'(ld_col) + CW'(1));
                    n_zero       = (ld_row == '0);
                end else if (in_acc) begin
                    n_status = q_status;
                    n_step   = '0;
                    n_top    = (qy > qr) ? qy - qr : '0;
                    n_bot    = (ysum < CW'(h_eff)) ? ysum : CW'(h_eff);
                    n_left   = (qx > qr) ? qx - qr : '0;
                    n_right  = (xsum < CW'(w_eff)) ? xsum : CW'(w_eff);
                    px_raddr = AW'(qy) * AW'(MAX_WIDTH) + AW'(qx);
                end
            end
            S_LD_WR: begin
                ps_we = 1'b1;
                if (col_inc >= (DWX + 1)'(w_eff)) begin
                    n_col  = '0;
                    n_rsum = '0;
                    if (row_inc >= (DWY + 1)'(h_eff)) begin
                        n_row        = '0;
                        n_frame_done = 1'b1;
                    end else begin
                        n_row = DWY'(row_inc);
                    end
                end else begin
                    n_col = DWX'(col_inc);
                end
            end
            S_Q_RD: begin
                // corners in order: BR, TR, BL, TL; data lands in the following step
                case (r_step)
                    3'd0: begin rr = r_bot; cc = r_right; end
                    3'd1: begin rr = r_top; cc = r_right; end
                    3'd2: begin rr = r_bot; cc = r_left;  end
                    default: begin rr = r_top; cc = r_left; end
                endcase
                ps_raddr = sat_addr(rr, cc);
                n_zero   = (rr == '0) || (cc == '0);
                n_step   = r_step + 3'd1;
                case (r_step)
                    3'd0: begin
                        n_pix  = px_rdata;
                        n_area = AREA_W'(r_right - r_left) * AREA_W'(r_bot - r_top);
                    end
                    3'd1:    n_acc = rd_sat;
                    3'd2:    n_acc = r_acc - rd_sat;
                    3'd3:    n_acc = r_acc - rd_sat;
                    default: n_acc = r_acc + rd_sat;
                endcase
            end
            S_DIV_GO: begin
                div_start = 1'b1;
            end
            S_DIV_WAIT: begin
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    if (r_status != ST_OK) begin
                        n_out_pix = '0;
                    end else if (lift < {1'b0, div_quo}) begin
                        n_out_pix = '0;
                    end else if (diff > {1'b0, PIX_MAX}) begin
                        n_out_pix = PIX_MAX;
                    end else begin
                        n_out_pix = PIX_W'(diff);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_w      <= RST_FRAME_WIDTH;
            r_cfg_h      <= RST_FRAME_HEIGHT;
            r_radius     <= RST_RADIUS;
            r_base       <= RST_BASELINE;
            r_col        <= '0;
            r_row        <= '0;
            r_rsum       <= '0;
            r_frame_done <= 1'b0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (cfg_restart) begin
                r_col        <= '0;
                r_row        <= '0;
                r_rsum       <= '0;
                r_frame_done <= 1'b0;
            end else begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_rsum       <= n_rsum;
                r_frame_done <= n_frame_done;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_cfg_w  <= DIM_W'(i_cfg_data);
                    REG_FRAME_HEIGHT: r_cfg_h  <= DIM_W'(i_cfg_data);
                    REG_RADIUS:       r_radius <= RAD_W'(i_cfg_data);
                    REG_BASELINE:     r_base   <= PIX_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
        r_top        <= n_top;
        r_bot        <= n_bot;
        r_left       <= n_left;
        r_right      <= n_right;
        r_acc        <= n_acc;
        r_zero       <= n_zero;
        r_area       <= n_area;
        r_pix        <= n_pix;
        r_status     <= n_status;
        r_out_pix    <= n_out_pix;
        r_out_status <= n_out_status;
    end

    lbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (px_we),
        .i_waddr (px_waddr),
        .i_wdata (px_wdata),
        .i_raddr (px_raddr),
        .o_rdata (px_rdata)
    );

    // summed-area table without its zero border row and column
    lbs_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_sat_ram (
        .i_clk   (i_clk),
        .i_we    (ps_we),
        .i_waddr (ps_waddr),
        .i_wdata (ps_wdata),
        .i_raddr (ps_raddr),
        .o_rdata (ps_rdata)
    );

    lbs_div #(
        .DIVD_W (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_area),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_out_valid       = r_out_valid;
    assign o_corrected_pixel = r_out_pix;
    assign o_status          = r_out_status;

    a_load_writes_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_LOAD)) |=> (r_state == S_LD_WR))
        else $error("load not followed by table write");

    a_ok_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && (r_status == ST_OK)) |-> r_frame_done)
        else $error("good result without complete frame");

    a_area_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_GO) |-> (r_area != '0))
        else $error("zero window area at divide");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside wait state");

endmodule
